>>> sv/room_allocation_most_booked_defines.svh
// assertion macros for the room allocation block
`ifndef ROOM_ALLOCATION_MOST_BOOKED_DEFINES_SVH
`define ROOM_ALLOCATION_MOST_BOOKED_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define RAMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define RAMA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RAMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAMA_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/rama_pkg.sv
// shared widths, constants and types of the room allocation block
package rama_pkg;

    localparam int TIME_W  = 32;
    localparam int FREE_W  = 48;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 8;
    localparam int ROOM_W  = 7;

    localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    // one entry of the room store
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [FREE_W-1:0] free;
    } t_room;

    // results of the shared compare and add unit
    typedef struct packed {
        logic              le_start;
        logic              lt_best;
        logic              gt_max;
        logic [CNT_W-1:0]  cnt_inc;
        logic [FREE_W-1:0] free_dly;
    } t_alu_res;

endpackage

>>> sv/rama_cfg_if.sv
// configuration write channel carrying the room count
interface rama_cfg_if import rama_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] room_count;

    modport source (output valid, output room_count, input ready);
    modport sink   (input valid, input room_count, output ready);
endinterface

>>> sv/rama_mtg_if.sv
// meeting input channel
interface rama_mtg_if import rama_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last_meeting;

    modport source (output valid, output start_time, output end_time, output last_meeting,
                    input ready);
    modport sink   (input valid, input start_time, input end_time, input last_meeting,
                    output ready);
endinterface

>>> sv/rama_res_if.sv
// result channel carrying the busiest room and its count
interface rama_res_if import rama_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROOM_W-1:0] busiest_room;
    logic [CNT_W-1:0]  busiest_count;

    modport source (output valid, output busiest_room, output busiest_count, input ready);
    modport sink   (input valid, input busiest_room, input busiest_count, output ready);
endinterface

>>> sv/rama_room_mem.sv
// room store: one write port, one registered read port
module rama_room_mem import rama_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_room         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_room         o_rdata
);

    t_room r_mem [DEPTH];
    t_room r_rdata;

    // write then registered read, read sees the old word on a same-address clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/rama_alu.sv
// shared compare and saturating add unit used on every scan step
module rama_alu import rama_pkg::*; (
    input  logic [FREE_W-1:0] i_free,
    input  logic [FREE_W-1:0] i_best_free,
    input  logic [CNT_W-1:0]  i_cnt,
    input  logic [CNT_W-1:0]  i_max,
    input  logic [TIME_W-1:0] i_start,
    input  logic [TIME_W-1:0] i_end,
    output t_alu_res          o_res
);

    logic [TIME_W-1:0] w_dur;
    logic [FREE_W:0]   w_sum;

    // delay is the meeting length, zero when end is not after start
    assign w_dur = (i_end > i_start) ? (i_end - i_start) : '0;
    assign w_sum = {1'b0, i_best_free} + (FREE_W + 1)'(w_dur);

    always_comb begin
        o_res.le_start = i_free <= FREE_W'(i_start);
        o_res.lt_best  = i_free < i_best_free;
        o_res.gt_max   = i_cnt > i_max;
        o_res.cnt_inc  = (i_cnt == CNT_MAX) ? i_cnt : i_cnt + 1'b1;
        o_res.free_dly = w_sum[FREE_W] ? FREE_MAX : w_sum[FREE_W-1:0];
    end

endmodule

>>> sv/room_allocation_most_booked.sv
// top level: meeting room allocation with most-booked room report
//
// Channels: i_cfg writes the room count (taken at any cycle, meant for idle
// periods), i_mtg carries one meeting per transfer in ascending start order,
// o_res carries the busiest room and its count after the meeting marked last.
// Each meeting scans the rooms in use one per cycle through the room store and
// the shared compare unit; the input is held while a meeting is scanned, as
// the store has a single read port, and is ready again once a meeting other than the last is placed.
// The last meeting then sweeps all MAX_ROOMS entries, finding the busiest room
// in use and clearing the store; the result is then loaded into the output
// register once that is free, and the input is ready again at that point.
// Reset is synchronous: the room count returns to one and a clearing pass over
// all MAX_ROOMS entries zeroes the store before the first meeting is taken.
// A stalled receiver holds the result in its register; meetings keep being
// taken meanwhile and only a second result waits for the first transfer.
`include "room_allocation_most_booked_defines.svh"

module room_allocation_most_booked import rama_pkg::*; #(
    parameter int MAX_ROOMS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rama_cfg_if.sink   i_cfg,
    rama_mtg_if.sink   i_mtg,
    rama_res_if.source o_res
);

    localparam int AW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CW = $clog2(MAX_ROOMS + 1);
    localparam logic [CW-1:0] ROOMS_MAX = CW'(MAX_ROOMS);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state            r_state,      n_state;
    logic [CFG_W-1:0]  r_room_count, n_room_count;
    logic [CW-1:0]     r_rd_addr,    n_rd_addr;
    logic              r_chk_valid,  n_chk_valid;
    logic [AW-1:0]     r_chk_idx,    n_chk_idx;
    logic [TIME_W-1:0] r_start,      n_start;
    logic [TIME_W-1:0] r_end,        n_end;
    logic              r_last,       n_last;
    logic [FREE_W-1:0] r_best_free,  n_best_free;
    logic [CNT_W-1:0]  r_best_cnt,   n_best_cnt;
    logic [AW-1:0]     r_best_idx,   n_best_idx;
    logic              r_report,     n_report;
    logic [CNT_W-1:0]  r_max_cnt,    n_max_cnt;
    logic [AW-1:0]     r_max_idx,    n_max_idx;
    logic              r_out_valid,  n_out_valid;
    logic [ROOM_W-1:0] r_out_room,   n_out_room;
    logic [CNT_W-1:0]  r_out_count,  n_out_count;

    logic [CW-1:0]     w_rooms;
    logic              w_miss;
    logic [31:0]       w_max_wide;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_room             mem_wdata;
    t_room             mem_rdata;
    t_alu_res          alu_res;

    // rooms in use: zero means one, above the store depth saturates
    always_comb begin
        if (r_room_count == '0) begin
            w_rooms = CW'(1);
        end else if (32'(r_room_count) > 32'(MAX_ROOMS)) begin
            w_rooms = ROOMS_MAX;
        end else begin
            w_rooms = CW'(r_room_count);
        end
    end

    // scan has run past the last room without a free one
    assign w_miss = (r_state == S_SCAN) && !r_chk_valid && (r_rd_addr == w_rooms);
    assign w_max_wide = 32'(r_max_idx);

    // room store
    rama_room_mem #(
        .DEPTH (MAX_ROOMS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // shared compare and add unit
    rama_alu u_alu (
        .i_free      (mem_rdata.free),
        .i_best_free (r_best_free),
        .i_cnt       (w_miss ? r_best_cnt : mem_rdata.cnt),
        .i_max       (r_max_cnt),
        .i_start     (r_start),
        .i_end       (r_end),
        .o_res       (alu_res)
    );

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_room_count = r_room_count;
        n_rd_addr    = r_rd_addr;
        n_chk_valid  = r_chk_valid;
        n_chk_idx    = r_chk_idx;
        n_start      = r_start;
        n_end        = r_end;
        n_last       = r_last;
        n_best_free  = r_best_free;
        n_best_cnt   = r_best_cnt;
        n_best_idx   = r_best_idx;
        n_report     = r_report;
        n_max_cnt    = r_max_cnt;
        n_max_idx    = r_max_idx;
        n_out_valid  = r_out_valid;
        n_out_room   = r_out_room;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_chk_idx;
        mem_wdata    = '0;

        // configuration transfer
        if (i_cfg.valid) begin
            n_room_count = i_cfg.room_count;
        end

        // result transfer frees the output register
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                // read every entry, note the busiest room in use when reporting, write zero behind it
                if (r_rd_addr != ROOMS_MAX) begin
                    n_rd_addr   = CW'(r_rd_addr + 1'b1);
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_rd_addr[AW-1:0];
                end else begin
                    n_chk_valid = 1'b0;
                end
                if (r_chk_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_idx;
                    if (r_report && (CW'(r_chk_idx) < w_rooms) && alu_res.gt_max) begin
                        n_max_cnt = mem_rdata.cnt;
                        n_max_idx = r_chk_idx;
                    end
                end else if (r_rd_addr == ROOMS_MAX) begin
                    n_state = r_report ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_mtg.valid) begin
                    n_start     = i_mtg.start_time;
                    n_end       = i_mtg.end_time;
                    n_last      = i_mtg.last_meeting;
                    n_rd_addr   = '0;
                    n_chk_valid = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue the next room read
                if (r_rd_addr != w_rooms) begin
                    n_rd_addr   = CW'(r_rd_addr + 1'b1);
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_rd_addr[AW-1:0];
                end else begin
                    n_chk_valid = 1'b0;
                end
                if (r_chk_valid) begin
                    if (alu_res.le_start) begin
                        // free room: book it until the meeting end
                        mem_we         = 1'b1;
                        mem_waddr      = r_chk_idx;
                        mem_wdata.cnt  = alu_res.cnt_inc;
                        mem_wdata.free = FREE_W'(r_end);
                    end else if (r_chk_idx == '0 || alu_res.lt_best) begin
                        // earliest freeing room so far
                        n_best_free = mem_rdata.free;
                        n_best_cnt  = mem_rdata.cnt;
                        n_best_idx  = r_chk_idx;
                    end
                end else if (w_miss) begin
                    // no room free: delay into the earliest freeing room
                    mem_we         = 1'b1;
                    mem_waddr      = r_best_idx;
                    mem_wdata.cnt  = alu_res.cnt_inc;
                    mem_wdata.free = alu_res.free_dly;
                end
                // meeting placed
                if (mem_we) begin
                    n_chk_valid = 1'b0;
                    n_rd_addr   = '0;
                    if (r_last) begin
                        n_state   = S_SWEEP;
                        n_report  = 1'b1;
                        n_max_cnt = '0;
                        n_max_idx = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                // load the result once the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_room  = w_max_wide[ROOM_W-1:0];
                    n_out_count = r_max_cnt;
                    n_report    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_room_count <= CFG_W'(1);
            r_rd_addr    <= '0;
            r_chk_valid  <= 1'b0;
            r_report     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_room_count <= n_room_count;
            r_rd_addr    <= n_rd_addr;
            r_chk_valid  <= n_chk_valid;
            r_report     <= n_report;
            r_out_valid  <= n_out_valid;
        end
        r_chk_idx   <= n_chk_idx;
        r_start     <= n_start;
        r_end       <= n_end;
        r_last      <= n_last;
        r_best_free <= n_best_free;
        r_best_cnt  <= n_best_cnt;
        r_best_idx  <= n_best_idx;
        r_max_cnt   <= n_max_cnt;
        r_max_idx   <= n_max_idx;
        r_out_room  <= n_out_room;
        r_out_count <= n_out_count;
    end

    // channel outputs
    assign i_cfg.ready         = 1'b1;
    assign i_mtg.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.busiest_room  = r_out_room;
    assign o_res.busiest_count = r_out_count;

    // checks
    `RAMA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_mtg.valid && i_mtg.ready |=> !i_mtg.ready, "meeting taken while a scan is running")
    `RAMA_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_rd_addr <= w_rooms), "scan address past the rooms in use")
    `RAMA_NEVER(a_no_idle_write, i_clk, i_rst_n, mem_we && (r_state == S_IDLE || r_state == S_OUT), "room store written outside a scan or sweep")
    `RAMA_ASSERT(a_result_after_sweep, i_clk, i_rst_n, $rose(o_res.valid) |-> ($past(r_state) == S_OUT), "result shown without a finished sweep")

endmodule
